// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Depends on nothing; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds whenever ante holds, outside of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that expr holds at every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/afu_pkg.sv =====
// Package of the AES field arithmetic unit: opcodes, stage types, GF(2^8) helpers.
// Holds the inverse and S-box tables, built at elaboration. Depends on nothing.
`timescale 1ns / 1ps

package afu_pkg;

  // Operation codes.
  typedef enum logic [2:0] {
    KIND_ADD   = 3'd0,
    KIND_XTIME = 3'd1,
    KIND_MUL   = 3'd2,
    KIND_INV   = 3'd3,
    KIND_SBOX  = 3'd4,
    KIND_WADD  = 3'd5,
    KIND_WMUL  = 3'd6,
    KIND_WROT  = 3'd7
  } kind_e;

  localparam logic [8:0] POLY_REDUCE = 9'h11B;
  localparam logic [7:0] SBOX_CONST  = 8'h63;

  // Carry-less product of two bytes is 15 bits wide.
  typedef logic [14:0] clprod_t;

  // Contents of the first pipeline register.
  typedef struct packed {
    logic                   valid;
    kind_e                  kind;
    logic [31:0]            simple;
    logic [3:0][3:0][14:0]  prod;
  } s1_t;

  // Carry-less multiply of two bytes.
  function automatic clprod_t clmul8(input logic [7:0] x, input logic [7:0] y);
    clprod_t acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc = acc ^ (clprod_t'(x) << k);
      end
    end
    return acc;
  endfunction

  // Reduction of a carry-less product modulo the AES polynomial.
  function automatic logic [7:0] reduce15(input clprod_t p);
    clprod_t r;
    r = p;
    for (int k = 14; k >= 8; k--) begin
      if (r[k]) begin
        r = r ^ (clprod_t'(POLY_REDUCE) << (k - 8));
      end
    end
    return r[7:0];
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    return reduce15(clmul8(x, y));
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
    return 8'((v << n) | (v >> (8 - n)));
  endfunction

  // Inverse as x^254, zero maps to zero; evaluated at elaboration only.
  function automatic logic [255:0][7:0] build_inv_table();
    logic [255:0][7:0] t;
    logic [7:0]        sq;
    logic [7:0]        acc;
    for (int x = 0; x < 256; x++) begin
      sq  = 8'(x);
      acc = 8'h01;
      for (int k = 1; k < 8; k++) begin
        sq  = gf_mul(sq, sq);
        acc = gf_mul(acc, sq);
      end
      t[x] = (x == 0) ? 8'h00 : acc;
    end
    return t;
  endfunction

  localparam logic [255:0][7:0] INV_TABLE = build_inv_table();

  // S-box: inverse, affine matrix, then the constant.
  function automatic logic [255:0][7:0] build_sbox_table();
    logic [255:0][7:0] t;
    logic [7:0]        q;
    for (int x = 0; x < 256; x++) begin
      q    = INV_TABLE[x];
      t[x] = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ SBOX_CONST;
    end
    return t;
  endfunction

  localparam logic [255:0][7:0] SBOX_TABLE = build_sbox_table();

endpackage

// ===== hw/rtl/afu_clmul_stage.sv =====
// First compute stage: sixteen byte carry-less products and the table/logic ops.
// Depends on afu_pkg.
`timescale 1ns / 1ps

module afu_clmul_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  afu_pkg::kind_e kind_i,
  input  logic [31:0]   operand_a_i,
  input  logic [31:0]   operand_b_i,
  output afu_pkg::s1_t  s1_o
);
  import afu_pkg::*;

  logic [3:0][7:0]       a_bytes;
  logic [3:0][7:0]       b_bytes;
  logic [31:0]           simple_d;
  logic [3:0][3:0][14:0] prod_d;
  logic                  valid_q;
  kind_e                 kind_q;
  logic [31:0]           simple_q;
  logic [3:0][3:0][14:0] prod_q;

  assign a_bytes = operand_a_i;
  assign b_bytes = operand_b_i;

  // Product j,i pairs byte (j-i) mod 4 of a with byte i of b.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        prod_d[j][i] = clmul8(a_bytes[2'(j - i)], b_bytes[i]);
      end
    end
  end

  // Operations that need none of the carry-less products.
  always_comb begin
    case (kind_i)
      KIND_ADD:   simple_d = {24'h0, a_bytes[0] ^ b_bytes[0]};
      KIND_XTIME: simple_d = {24'h0, reduce15(clprod_t'({a_bytes[0], 1'b0}))};
      KIND_INV:   simple_d = {24'h0, INV_TABLE[a_bytes[0]]};
      KIND_SBOX:  simple_d = {24'h0, SBOX_TABLE[a_bytes[0]]};
      KIND_WADD:  simple_d = operand_a_i ^ operand_b_i;
      KIND_WROT:  simple_d = {operand_a_i[23:0], operand_a_i[31:24]};
      default:    simple_d = '0;
    endcase
  end

  // Valid bit is reset; the payload is not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_i;
    simple_q <= simple_d;
    prod_q   <= prod_d;
  end

  assign s1_o.valid  = valid_q;
  assign s1_o.kind   = kind_q;
  assign s1_o.simple = simple_q;
  assign s1_o.prod   = prod_q;

endmodule

// ===== hw/rtl/afu_reduce_stage.sv =====
// Second compute stage: sums and reduces the products, selects the result.
// Depends on afu_pkg.
`timescale 1ns / 1ps

module afu_reduce_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  afu_pkg::s1_t s1_i,
  output logic         done_o,
  output logic [31:0]  result_o
);
  import afu_pkg::*;

  logic [3:0][7:0] word_mul;
  logic [31:0]     result_d;
  logic            done_q;
  logic [31:0]     result_q;

  // Each result byte of the word multiply: XOR of four products, then reduce.
  always_comb begin
    clprod_t acc;
    for (int j = 0; j < 4; j++) begin
      acc = s1_i.prod[j][0] ^ s1_i.prod[j][1] ^ s1_i.prod[j][2] ^ s1_i.prod[j][3];
      word_mul[j] = reduce15(acc);
    end
  end

  // Byte multiply reuses the product of the two low bytes.
  always_comb begin
    case (s1_i.kind)
      KIND_MUL:  result_d = {24'h0, reduce15(s1_i.prod[0][0])};
      KIND_WMUL: result_d = word_mul;
      default:   result_d = s1_i.simple;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== hw/rtl/aes_field_arithmetic_unit_core.sv =====
// An item passes the input register, the product register and the output register;
// done_o comes out registered together with the result. Throughput: one item per cycle.
// busy is always low and the pipeline never stalls.
// Stages: input register, product register, reduction and output register.
// Reset clears the valid bits of all three stages; no item is lost after reset ends.
// Depends on afu_pkg, afu_clmul_stage and afu_reduce_stage.
`timescale 1ns / 1ps

module aes_field_arithmetic_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] result_o
);
  import afu_pkg::*;

  logic        in_valid_q;
  kind_e       kind_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  s1_t         s1;

  // Every stage moves each cycle, so the unit always takes an item.
  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_e'(kind_i);
    a_q    <= operand_a_i;
    b_q    <= operand_b_i;
  end

  afu_clmul_stage u_afu_clmul_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .kind_i      (kind_q),
    .operand_a_i (a_q),
    .operand_b_i (b_q),
    .s1_o        (s1)
  );

  afu_reduce_stage u_afu_reduce_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s1_i     (s1),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// ===== hw/rtl/afu_checker.sv =====
// Port-level checker for the AES field arithmetic unit, bound to the top level.
// Depends on afu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module afu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  kind_i,
  input logic [31:0] operand_a_i,
  input logic [31:0] operand_b_i,
  input logic        done_o,
  input logic [31:0] result_o
);
  import afu_pkg::*;

  logic [2:0] rst_hist_q;
  logic       hist_ok;

  // Reset has stayed released until rst_hist_q is all ones, so the pipeline holds real history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_hist_q <= '0;
    end else begin
      rst_hist_q <= {rst_hist_q[1:0], 1'b1};
    end
  end

  assign hist_ok = &rst_hist_q;

  // Every accepted item comes out, and done_o rises for no other.
  `ASSERT_IMPLIES(a_latency, clk_i, rst_ni, hist_ok, done_o == $past(start && !busy, 3))

  // Byte operations leave the upper result bits zero.
  `ASSERT_IMPLIES(a_byte_upper, clk_i, rst_ni, hist_ok && done_o && $past(kind_i, 3) <= KIND_SBOX, result_o[31:8] == 24'h0)

  // Word rotate moves each byte up by one place.
  `ASSERT_IMPLIES(a_word_rot, clk_i, rst_ni, hist_ok && done_o && $past(kind_i, 3) == KIND_WROT, result_o == {$past(operand_a_i[23:0], 3), $past(operand_a_i[31:24], 3)})

  // Word add is a plain XOR of the operands.
  `ASSERT_IMPLIES(a_word_add, clk_i, rst_ni, hist_ok && done_o && $past(kind_i, 3) == KIND_WADD, result_o == ($past(operand_a_i, 3) ^ $past(operand_b_i, 3)))

endmodule

bind aes_field_arithmetic_unit_core afu_checker u_afu_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the AES field arithmetic unit core.
// Predicts each result with its own GF(2^8) arithmetic and compares results in order.
// Depends on afu_pkg and aes_field_arithmetic_unit_core.
`timescale 1ns / 1ps

module testbench;
  import afu_pkg::*;

  // Predicts field results and holds them until the block returns them.
  class field_op_scoreboard;
    logic [31:0] expected_results[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    // Shift-and-add multiply, reducing by the AES polynomial after each doubling.
    function logic [7:0] ff_mul(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] acc;
      logic [7:0] cur;
      logic [7:0] rest;
      acc  = 8'h00;
      cur  = x;
      rest = y;
      while (rest != 8'h00) begin
        if (rest[0]) begin
          acc = acc ^ cur;
        end
        cur  = cur[7] ? ((cur << 1) ^ 8'h1B) : (cur << 1);
        rest = rest >> 1;
      end
      return acc;
    endfunction

    // Inverse found by search; zero has none and maps to zero.
    function logic [7:0] ff_inverse(input logic [7:0] x);
      logic [7:0] found;
      found = 8'h00;
      if (x != 8'h00) begin
        for (int y = 1; y < 256; y++) begin
          if (ff_mul(x, 8'(y)) == 8'h01) begin
            found = 8'(y);
          end
        end
      end
      return found;
    endfunction

    // Affine step written bit by bit: bit i takes bits i, i+4, i+5, i+6 and i+7.
    function logic [7:0] ff_sbox(input logic [7:0] x);
      logic [7:0] q;
      logic [7:0] s;
      logic [7:0] affine_const;
      affine_const = 8'h63;
      q = ff_inverse(x);
      for (int i = 0; i < 8; i++) begin
        s[i] = q[i] ^ q[(i + 4) % 8] ^ q[(i + 5) % 8] ^ q[(i + 6) % 8] ^ q[(i + 7) % 8]
               ^ affine_const[i];
      end
      return s;
    endfunction

    // Word product modulo x^4+1.
    function logic [31:0] word_mix(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] mixed;
      logic [7:0]  acc;
      for (int j = 0; j < 4; j++) begin
        acc = 8'h00;
        for (int i = 0; i < 4; i++) begin
          acc = acc ^ ff_mul(a[8 * ((j - i + 4) % 4) +: 8], b[8 * i +: 8]);
        end
        mixed[8 * j +: 8] = acc;
      end
      return mixed;
    endfunction

    function logic [31:0] field_result(input kind_e kind, input logic [31:0] a,
                                       input logic [31:0] b);
      logic [31:0] r;
      case (kind)
        KIND_ADD:   r = {24'h0, a[7:0] ^ b[7:0]};
        KIND_XTIME: r = {24'h0, ff_mul(a[7:0], 8'h02)};
        KIND_MUL:   r = {24'h0, ff_mul(a[7:0], b[7:0])};
        KIND_INV:   r = {24'h0, ff_inverse(a[7:0])};
        KIND_SBOX:  r = {24'h0, ff_sbox(a[7:0])};
        KIND_WADD:  r = a ^ b;
        KIND_WMUL:  r = word_mix(a, b);
        default:    r = {a[23:0], a[31:24]};
      endcase
      return r;
    endfunction

    function void note_item(input kind_e kind, input logic [31:0] a, input logic [31:0] b);
      expected_results.push_back(field_result(kind, a, b));
    endfunction

    function void check_result(input logic [31:0] actual);
      logic [31:0] want;
      if (expected_results.size() == 0) begin
        $error("result: unexpected item, actual %h", actual);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (actual !== want) begin
          $error("result: expected %h, actual %h", want, actual);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  kind_i;
  logic [31:0] operand_a_i;
  logic [31:0] operand_b_i;
  logic        done_o;
  logic [31:0] result_o;

  field_op_scoreboard board;

  aes_field_arithmetic_unit_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .kind_i      (kind_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #4 clk_i = ~clk_i;

  // Accepted items and returned results, both sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        board.note_item(kind_e'(kind_i), operand_a_i, operand_b_i);
      end
      if (done_o) begin
        board.check_result(result_o);
      end
    end
  end

  // Presents one item and holds it until the block accepts it.
  task automatic issue(input kind_e kind, input logic [31:0] a, input logic [31:0] b);
    start       <= 1'b1;
    kind_i      <= kind;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
  endtask

  // Drops start for a number of cycles; zero keeps the stream back to back.
  task automatic idle(input int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Operands with a bias toward the corners of the field.
  function automatic logic [31:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return {24'($urandom), 8'($urandom_range(0, 1))};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned burst_free;
    board = new();
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    kind_i      <= KIND_ADD;
    operand_a_i <= '0;
    operand_b_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: corners of every operation, including ignored operand bits.
    issue(KIND_ADD, 32'h0000_00FF, 32'h0000_00FF);
    issue(KIND_ADD, 32'hFFFF_FF00, 32'hABCD_EF5A);
    issue(KIND_XTIME, 32'h0000_0080, 32'h0000_0000);
    issue(KIND_XTIME, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KIND_XTIME, 32'h1234_5657, 32'h0000_0000);
    issue(KIND_MUL, 32'h0000_0057, 32'h0000_0083);
    issue(KIND_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KIND_MUL, 32'h0000_00A5, 32'hFFFF_FF00);
    issue(KIND_MUL, 32'h0000_0001, 32'h0000_00C3);
    issue(KIND_INV, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(KIND_INV, 32'hFFFF_FF00, 32'h0000_0000);
    issue(KIND_INV, 32'h0000_0001, 32'h0000_0000);
    issue(KIND_INV, 32'h0000_0053, 32'h0000_0000);
    issue(KIND_INV, 32'h0000_00FF, 32'h0000_0000);
    issue(KIND_SBOX, 32'h0000_0000, 32'h0000_0000);
    issue(KIND_SBOX, 32'h0000_0053, 32'hFFFF_FFFF);
    issue(KIND_SBOX, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(KIND_WADD, 32'hFFFF_FFFF, 32'h0F0F_F0F0);
    issue(KIND_WMUL, 32'h0301_0102, 32'hD4BF_5D30);
    issue(KIND_WMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(KIND_WMUL, 32'h0000_0001, 32'h89AB_CDEF);
    issue(KIND_WROT, 32'h1234_5678, 32'hFFFF_FFFF);
    issue(KIND_WROT, 32'hFF00_0000, 32'h0000_0000);

    // The sender holds off until every directed result is back.
    wait_drained();

    // Random items; every third block of a hundred runs with no gaps at all.
    for (int i = 0; i < 1000; i++) begin
      burst_free = ((i / 100) % 3 == 1) ? 1 : 0;
      issue(kind_e'($urandom_range(0, 7)), pick_operand(), pick_operand());
      if (i == 500) begin
        wait_drained();
      end else if (burst_free == 0) begin
        idle(gap_len());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("result: %0d expected items never arrived", board.pending());
      board.failures++;
    end
    if (board.failures == 0) begin
      $display("aes_field_arithmetic_unit_core verification clean");
    end else begin
      $display("aes_field_arithmetic_unit_core verification failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("aes_field_arithmetic_unit_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/afu_pkg.sv
hw/rtl/afu_clmul_stage.sv
hw/rtl/afu_reduce_stage.sv
hw/rtl/aes_field_arithmetic_unit_core.sv
hw/rtl/afu_checker.sv
bench/testbench.sv
